@@ src/arc_pkg.sv @@
// Shared types and constants of the allocation region checker.
// Used by the controller, the datapath and the top level; no dependencies.
package arc_pkg;

   localparam int DefaultEntries = 64;

   typedef enum logic [3:0] {
      ACT_REM_STACK   = 4'd0,
      ACT_REM_GLOBAL  = 4'd1,
      ACT_REM_HEAP    = 4'd2,
      ACT_FREE        = 4'd3,
      ACT_REALLOC     = 4'd4,
      ACT_CHK_REALLOC = 4'd5,
      ACT_CHK_STACK   = 4'd6,
      ACT_CHK_GLOBAL  = 4'd7,
      ACT_CHK_HEAP    = 4'd8,
      ACT_CHK_ANY     = 4'd9,
      ACT_MARK        = 4'd10,
      ACT_DESTROY     = 4'd11,
      ACT_POP_FRAME   = 4'd12,
      ACT_LEAKS       = 4'd13,
      ACT_FAIL        = 4'd14,
      ACT_NONE        = 4'd15
   } action_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_OUT_OF_RANGE = 4'd1,
      ST_INVALID_PTR  = 4'd2,
      ST_FREED_DEREF  = 4'd3,
      ST_FREE_UNALLOC = 4'd4,
      ST_DOUBLE_FREE  = 4'd5,
      ST_REALLOC_FREED = 4'd6,
      ST_REALLOC_NONDYN = 4'd7,
      ST_LEAK         = 4'd8,
      ST_INVALID_DEREF = 4'd9,
      ST_TABLE_FULL   = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      KIND_HEAP   = 2'd0,
      KIND_STACK  = 2'd1,
      KIND_GLOBAL = 2'd2,
      KIND_FREED  = 2'd3
   } kind_type;

   // Scan results per kind, returned by the datapath after a sweep.
   typedef struct packed {
      logic [4:0] addr_hit;  // address match found per kind, bit 4 = any stack
      logic       free_ok;   // a free slot exists
   } scan_status_type;

   // Datapath write commands.
   typedef enum logic [3:0] {
      WR_NONE,
      WR_SIZE,        // replace size of hit entry of kind
      WR_REVIVE,      // freed hit becomes kind, new age
      WR_CREATE,      // fill free slot
      WR_TO_FREED,    // heap hit becomes freed
      WR_REFILL,      // heap hit refilled at new address
      WR_MARK_INC,    // newest stack gains mark
      WR_KILL_HIT,    // drop stack hit
      WR_POP          // pop step on newest stack
   } wr_op_type;

   typedef struct packed {
      logic      scan_start;
      wr_op_type wr_op;
      kind_type  wr_kind;
      kind_type  hit_kind;
      logic      use_new_addr;
      logic      size_mul;
   } dp_cmd_type;

   typedef struct packed {
      logic            scan_done;
      scan_status_type scan;
      logic            heap_base_eq;  // heap hit base equals address
      logic            range_bad_heap;
      logic            range_bad_stack;
      logic            range_bad_global;
      logic            any_heap;
      logic            pop_more;      // newest stack had no mark and was dropped
   } dp_stat_type;

endpackage

@@ src/arc_datapath.sv @@
// Region table and sweep datapath of the allocation region checker.
// Depends on arc_pkg. Scans one entry per cycle and applies one write.
module arc_datapath #(
   parameter int TABLE_ENTRIES = arc_pkg::DefaultEntries
) (
   input  logic                clock,
   input  logic                reset,
   input  arc_pkg::dp_cmd_type cmd,
   input  logic [63:0]         address,
   input  logic [63:0]         region_size,
   input  logic [30:0]         element_count,
   input  logic [63:0]         new_address,
   input  logic [63:0]         access_length,
   output arc_pkg::dp_stat_type stat
);
   import arc_pkg::*;

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [63:0] base_mem [TABLE_ENTRIES];
   logic [63:0] size_mem [TABLE_ENTRIES];
   kind_type    kind_mem [TABLE_ENTRIES];
   logic [15:0] mark_mem [TABLE_ENTRIES];
   logic [47:0] age_mem  [TABLE_ENTRIES];
   logic [47:0] next_age_ff;

   // sweep state
   logic            busy_ff;
   logic [CntW-1:0] cnt_ff;
   logic            rd_vld_ff;
   logic [IdxW-1:0] rd_idx_ff;
   logic            done_ff;
   logic [63:0] rd_base_ff, rd_size_ff;
   kind_type    rd_kind_ff;
   logic [15:0] rd_mark_ff;
   logic [47:0] rd_age_ff;
   logic        rd_valid_ff;

   // per-kind best: index 0..3 by kind (address match), 4 = newest stack any
   logic [4:0]  hit_ff;
   logic [47:0] key_ff [5];
   logic [IdxW-1:0] idx_ff [5];
   logic [63:0] hbase_ff [5];
   logic [63:0] hsize_ff [5];
   logic [15:0] hmark_ff [5];
   logic            free_ok_ff;
   logic [IdxW-1:0] free_idx_ff;
   logic            any_heap_ff;

   logic [63:0] p_lo_ff;
   logic [31:0] p_hi_ff;
   logic [63:0] prod_ff;
   logic        pop_more_ff;

   logic        rd_match;
   logic [47:0] rd_key;
   logic [63:0] off;

   assign off      = address - rd_base_ff;
   assign rd_match = rd_base_ff <= address &&
                     (rd_base_ff == address || off < rd_size_ff);
   assign rd_key   = rd_age_ff - next_age_ff;

   function automatic logic rbad(input logic [63:0] b, input logic [63:0] s,
                                 input logic [63:0] a, input logic [63:0] l);
      return (l > s) || ((a - b) > (s - l));
   endfunction

   logic [IdxW-1:0] widx;
   kind_type        hk;

   always_comb begin
      hk = cmd.hit_kind;
      unique case (cmd.wr_op)
         WR_CREATE:              widx = free_idx_ff;
         WR_MARK_INC, WR_POP:    widx = idx_ff[4];
         default:                widx = idx_ff[hk];
      endcase
   end

   always_ff @(posedge clock) begin
      // two-stage product of the low and high halves; settles before any sweep ends
      p_lo_ff <= {32'd0, region_size[31:0]} * {33'd0, element_count};
      p_hi_ff <= region_size[63:32] * {1'b0, element_count};
      prod_ff <= p_lo_ff + {p_hi_ff, 32'd0};
      if (reset) begin
         valid_ff    <= '0;
         next_age_ff <= '0;
         busy_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         done_ff     <= 1'b0;
         pop_more_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         done_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
         if (cmd.scan_start) begin
            busy_ff    <= 1'b1;
            cnt_ff     <= '0;
            hit_ff     <= '0;
            free_ok_ff <= 1'b0;
            any_heap_ff <= 1'b0;
         end else if (busy_ff) begin
            if (cnt_ff == CntW'(TABLE_ENTRIES)) begin
               busy_ff <= 1'b0;
            end else begin
               rd_vld_ff   <= 1'b1;
               rd_idx_ff   <= cnt_ff[IdxW-1:0];
               rd_valid_ff <= valid_ff[cnt_ff[IdxW-1:0]];
               rd_base_ff  <= base_mem[cnt_ff[IdxW-1:0]];
               rd_size_ff  <= size_mem[cnt_ff[IdxW-1:0]];
               rd_kind_ff  <= kind_mem[cnt_ff[IdxW-1:0]];
               rd_mark_ff  <= mark_mem[cnt_ff[IdxW-1:0]];
               rd_age_ff   <= age_mem[cnt_ff[IdxW-1:0]];
               cnt_ff      <= cnt_ff + 1'b1;
            end
         end
         // accumulate the entry read in the previous cycle
         if (rd_vld_ff) begin
            if (!rd_valid_ff) begin
               if (!free_ok_ff) begin
                  free_ok_ff  <= 1'b1;
                  free_idx_ff <= rd_idx_ff;
               end
            end else begin
               if (rd_kind_ff == KIND_HEAP) any_heap_ff <= 1'b1;
               if (rd_match && (!hit_ff[rd_kind_ff] || rd_key > key_ff[rd_kind_ff])) begin
                  hit_ff[rd_kind_ff]   <= 1'b1;
                  key_ff[rd_kind_ff]   <= rd_key;
                  idx_ff[rd_kind_ff]   <= rd_idx_ff;
                  hbase_ff[rd_kind_ff] <= rd_base_ff;
                  hsize_ff[rd_kind_ff] <= rd_size_ff;
                  hmark_ff[rd_kind_ff] <= rd_mark_ff;
               end
               if (rd_kind_ff == KIND_STACK && (!hit_ff[4] || rd_key > key_ff[4])) begin
                  hit_ff[4]   <= 1'b1;
                  key_ff[4]   <= rd_key;
                  idx_ff[4]   <= rd_idx_ff;
                  hmark_ff[4] <= rd_mark_ff;
               end
            end
            if (rd_idx_ff == IdxW'(TABLE_ENTRIES - 1)) done_ff <= 1'b1;
         end
         // table writes
         pop_more_ff <= 1'b0;
         unique case (cmd.wr_op)
            WR_REVIVE, WR_TO_FREED: begin
               kind_mem[widx] <= cmd.wr_kind;
               age_mem[widx]  <= next_age_ff;
               next_age_ff    <= next_age_ff + 1'b1;
            end
            WR_CREATE, WR_REFILL: begin
               valid_ff[widx] <= 1'b1;
               kind_mem[widx] <= cmd.wr_kind;
               base_mem[widx] <= cmd.use_new_addr ? new_address : address;
               size_mem[widx] <= cmd.size_mul ? prod_ff : region_size;
               mark_mem[widx] <= '0;
               age_mem[widx]  <= next_age_ff;
               next_age_ff    <= next_age_ff + 1'b1;
            end
            WR_SIZE:
               size_mem[widx] <= cmd.size_mul ? prod_ff : region_size;
            WR_MARK_INC:
               if (hmark_ff[4] != 16'hFFFF) mark_mem[widx] <= hmark_ff[4] + 1'b1;
            WR_KILL_HIT:
               valid_ff[widx] <= 1'b0;
            WR_POP:
               if (hmark_ff[4] == 16'd0) begin
                  valid_ff[widx] <= 1'b0;
                  pop_more_ff    <= 1'b1;
               end else begin
                  mark_mem[widx] <= hmark_ff[4] - 1'b1;
               end
            default: ;
         endcase
      end
   end

   always_comb begin
      stat.scan_done        = done_ff;
      stat.scan.addr_hit    = hit_ff;
      stat.scan.free_ok     = free_ok_ff;
      stat.heap_base_eq     = hbase_ff[KIND_HEAP] == address;
      stat.range_bad_heap   = rbad(hbase_ff[KIND_HEAP], hsize_ff[KIND_HEAP],
                                   address, access_length);
      stat.range_bad_stack  = rbad(hbase_ff[KIND_STACK], hsize_ff[KIND_STACK],
                                   address, access_length);
      stat.range_bad_global = rbad(hbase_ff[KIND_GLOBAL], hsize_ff[KIND_GLOBAL],
                                   address, access_length);
      stat.any_heap         = any_heap_ff;
      stat.pop_more         = pop_more_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> busy_ff)
      else $error("sweep did not start");
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("sweep done while still reading");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op == WR_CREATE) |-> free_ok_ff)
      else $error("create without a free slot");
endmodule

@@ src/arc_controller.sv @@
// Action sequencer of the allocation region checker.
// Depends on arc_pkg; drives arc_datapath through command and status structs.
module arc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [3:0]           action,
   input  logic [63:0]          address,
   input  logic [63:0]          new_address,
   output arc_pkg::dp_cmd_type  cmd,
   input  arc_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_status
);
   import arc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_RESP} state_type;

   state_type  state_ff;
   action_type act_ff;
   status_type st;
   logic       rsp_valid_ff;
   logic [3:0] rsp_status_ff;
   dp_cmd_type c;
   logic       pop_wait_ff;

   logic [4:0] h;
   assign h = stat.scan.addr_hit;

   assign req_stall  = state_ff != S_IDLE || (rsp_valid_ff && rsp_stall);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign cmd        = c;

   // start sweeps, and decide write and status from the finished sweep
   always_comb begin
      c = '{scan_start: 1'b0, wr_op: WR_NONE, wr_kind: KIND_HEAP,
            hit_kind: KIND_HEAP, use_new_addr: 1'b0, size_mul: 1'b0};
      st = ST_OK;
      if (state_ff == S_IDLE && req_valid && !req_stall) c.scan_start = 1'b1;
      if (state_ff == S_WRITE && pop_wait_ff) c.scan_start = stat.pop_more;
      if (state_ff == S_SCAN && stat.scan_done) begin
         unique case (act_ff)
            ACT_REM_STACK, ACT_REM_GLOBAL, ACT_REM_HEAP: begin
               c.wr_kind  = act_ff == ACT_REM_STACK  ? KIND_STACK :
                            act_ff == ACT_REM_GLOBAL ? KIND_GLOBAL : KIND_HEAP;
               c.size_mul = act_ff != ACT_REM_GLOBAL;
               c.hit_kind = c.wr_kind;
               if (act_ff == ACT_REM_HEAP && (address == 64'd0 || h[KIND_HEAP])) begin
                  c.wr_op = WR_NONE;
               end else if (h[c.wr_kind]) begin
                  c.wr_op = WR_SIZE;
               end else if (h[KIND_FREED]) begin
                  c.wr_op = WR_REVIVE;
                  c.hit_kind = KIND_FREED;
               end else if (stat.scan.free_ok) begin
                  c.wr_op = WR_CREATE;
               end else begin
                  st = ST_TABLE_FULL;
               end
            end
            ACT_FREE:
               if (address != 64'd0) begin
                  if (h[KIND_HEAP] && stat.heap_base_eq) begin
                     c.wr_op = WR_TO_FREED;
                     c.wr_kind = KIND_FREED;
                  end else begin
                     st = h[KIND_FREED] ? ST_DOUBLE_FREE : ST_FREE_UNALLOC;
                  end
               end
            ACT_REALLOC:
               if (new_address != 64'd0) begin
                  c.use_new_addr = 1'b1;
                  if (address == 64'd0) begin
                     if (stat.scan.free_ok) c.wr_op = WR_CREATE;
                     else st = ST_TABLE_FULL;
                  end else if (h[KIND_HEAP]) begin
                     c.wr_op = WR_REFILL;
                  end
               end
            ACT_CHK_REALLOC:
               if (address != 64'd0) begin
                  if (h[KIND_FREED]) st = ST_REALLOC_FREED;
                  else if (h[KIND_STACK]) st = ST_REALLOC_NONDYN;
               end
            ACT_CHK_STACK:
               st = !h[KIND_STACK] ? ST_INVALID_PTR :
                    stat.range_bad_stack ? ST_OUT_OF_RANGE : ST_OK;
            ACT_CHK_GLOBAL:
               st = !h[KIND_GLOBAL] ? ST_INVALID_PTR :
                    stat.range_bad_global ? ST_OUT_OF_RANGE : ST_OK;
            ACT_CHK_HEAP, ACT_CHK_ANY: begin
               if (h[KIND_HEAP]) st = stat.range_bad_heap ? ST_OUT_OF_RANGE : ST_OK;
               else if (act_ff == ACT_CHK_ANY && h[KIND_STACK])
                  st = stat.range_bad_stack ? ST_OUT_OF_RANGE : ST_OK;
               else if (act_ff == ACT_CHK_ANY && h[KIND_GLOBAL])
                  st = stat.range_bad_global ? ST_OUT_OF_RANGE : ST_OK;
               else st = h[KIND_FREED] ? ST_FREED_DEREF : ST_INVALID_PTR;
            end
            ACT_MARK:      if (h[4]) c.wr_op = WR_MARK_INC;
            ACT_DESTROY:   if (h[KIND_STACK]) begin
               c.wr_op = WR_KILL_HIT;
               c.hit_kind = KIND_STACK;
            end
            ACT_POP_FRAME: if (h[4]) c.wr_op = WR_POP;
            ACT_LEAKS:     st = stat.any_heap ? ST_LEAK : ST_OK;
            ACT_FAIL:      st = ST_INVALID_DEREF;
            default:       st = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pop_wait_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE:
               if (c.scan_start) begin
                  act_ff   <= action_type'(action);
                  state_ff <= S_SCAN;
               end
            S_SCAN:
               if (stat.scan_done) begin
                  rsp_status_ff <= st;
                  pop_wait_ff   <= c.wr_op == WR_POP;
                  state_ff      <= c.wr_op == WR_POP ? S_WRITE : S_RESP;
               end
            S_WRITE: begin
               // pop result is visible in the cycle after the write
               pop_wait_ff <= 1'b0;
               if (!pop_wait_ff) state_ff <= S_WRITE;
               if (pop_wait_ff) state_ff <= stat.pop_more ? S_SCAN : S_RESP;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> rsp_valid_ff)
      else $error("result not raised");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("accepting while busy");
   assert property (@(posedge clock) disable iff (reset)
      c.scan_start |-> !(state_ff == S_SCAN))
      else $error("sweep restarted mid-sweep");
endmodule

@@ src/allocation_region_checker.sv @@
// Allocation region checker: keeps a table of memory regions and checks
// actions against it. Depends on arc_pkg, arc_controller, arc_datapath.
//
// Each item sweeps the whole region table one entry per cycle through a
// single read port; a frame pop repeats the sweep once for every unmarked
// stack region it removes. One item is in flight at a time, and the next
// is taken once the previous result has left the output register or is
// being taken.
module allocation_region_checker #(
   parameter int TABLE_ENTRIES = arc_pkg::DefaultEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [63:0] req_address,
   input  logic [63:0] req_region_size,
   input  logic [30:0] req_element_count,
   input  logic [63:0] req_new_address,
   input  logic [63:0] req_access_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status
);
   import arc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [63:0] addr_ff, size_ff, naddr_ff, len_ff;
   logic [30:0] cnt_ff;

   // hold the accepted item for the whole action
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         addr_ff  <= req_address;
         size_ff  <= req_region_size;
         naddr_ff <= req_new_address;
         len_ff   <= req_access_length;
         cnt_ff   <= req_element_count;
      end
   end

   arc_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall,
      .action(req_action), .address(addr_ff), .new_address(naddr_ff),
      .cmd, .stat, .rsp_valid, .rsp_stall, .rsp_status
   );

   arc_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock, .reset, .cmd,
      .address(addr_ff), .region_size(size_ff), .element_count(cnt_ff),
      .new_address(naddr_ff), .access_length(len_ff), .stat
   );
endmodule

@@ test/testbench.sv @@
// Self-checking bench for the allocation region checker: drives actions with random idling
// and stalls, predicts each status from a behavioural region table. Depends on arc_pkg.
module testbench;
   import arc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Entries = 64;
   localparam longint unsigned CycleLimit = 4000000;

   typedef struct packed {
      action_type act;
      logic [63:0] addr;
      logic [63:0] rsize;
      logic [30:0] count;
      logic [63:0] naddr;
      logic [63:0] len;
   } action_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_action = '0;
   logic [63:0] req_address = '0, req_region_size = '0, req_new_address = '0;
   logic [63:0] req_access_length = '0;
   logic [30:0] req_element_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_status;

   allocation_region_checker i_dut (.*);

   always #10 clock = ~clock;

   // region table mirror
   logic        tbl_valid [Entries];
   logic [63:0] tbl_base [Entries];
   logic [63:0] tbl_size [Entries];
   kind_type    tbl_kind [Entries];
   logic [15:0] tbl_marks [Entries];
   logic [47:0] tbl_age [Entries];
   logic [47:0] age_next;

   action_item_type pending_items[$];
   status_type expected_status[$];
   int send_idle_pct = 0, recv_stall_pct = 0;
   int errors = 0, sent = 0, received = 0;
   longint unsigned cycles = 0;

   function automatic logic [47:0] take_age();
      take_age = age_next;
      age_next = age_next + 48'd1;
   endfunction

   function automatic int find_region(kind_type k, logic [63:0] a, bit any_addr);
      int best;
      logic [47:0] best_key, key;
      best = -1;
      best_key = '0;
      for (int i = 0; i < Entries; i++) begin
         if (!tbl_valid[i] || tbl_kind[i] != k) continue;
         if (!any_addr && !(tbl_base[i] <= a &&
               (tbl_base[i] == a || a - tbl_base[i] < tbl_size[i]))) continue;
         key = tbl_age[i] - age_next;
         if (best < 0 || key > best_key) begin
            best = i;
            best_key = key;
         end
      end
      return best;
   endfunction

   function automatic status_type create_region(kind_type k, logic [63:0] b,
                                                logic [63:0] s);
      for (int i = 0; i < Entries; i++)
         if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_kind[i] = k;
            tbl_base[i] = b;
            tbl_size[i] = s;
            tbl_marks[i] = '0;
            tbl_age[i] = take_age();
            return ST_OK;
         end
      return ST_TABLE_FULL;
   endfunction

   function automatic status_type revive_or_create(kind_type k, logic [63:0] a,
                                                   logic [63:0] s);
      int f;
      f = find_region(KIND_FREED, a, 1'b0);
      if (f >= 0) begin
         tbl_kind[f] = k;
         tbl_age[f] = take_age();
         return ST_OK;
      end
      return create_region(k, a, s);
   endfunction

   function automatic status_type span_status(int i, logic [63:0] a, logic [63:0] l);
      if (l > tbl_size[i] || a - tbl_base[i] > tbl_size[i] - l) return ST_OUT_OF_RANGE;
      return ST_OK;
   endfunction

   function automatic status_type apply_action(action_item_type it);
      int n;
      logic [63:0] prod;
      status_type st;
      st = ST_OK;
      prod = it.rsize * {33'd0, it.count};
      case (it.act)
         ACT_REM_STACK: begin
            n = find_region(KIND_STACK, it.addr, 1'b0);
            if (n >= 0) tbl_size[n] = prod;
            else st = revive_or_create(KIND_STACK, it.addr, prod);
         end
         ACT_REM_GLOBAL: begin
            n = find_region(KIND_GLOBAL, it.addr, 1'b0);
            if (n >= 0) tbl_size[n] = it.rsize;
            else st = revive_or_create(KIND_GLOBAL, it.addr, it.rsize);
         end
         ACT_REM_HEAP:
            if (it.addr != 0 && find_region(KIND_HEAP, it.addr, 1'b0) < 0)
               st = revive_or_create(KIND_HEAP, it.addr, prod);
         ACT_FREE:
            if (it.addr != 0) begin
               n = find_region(KIND_HEAP, it.addr, 1'b0);
               if (n >= 0 && tbl_base[n] == it.addr) begin
                  tbl_kind[n] = KIND_FREED;
                  tbl_age[n] = take_age();
               end else
                  st = find_region(KIND_FREED, it.addr, 1'b0) >= 0 ?
                       ST_DOUBLE_FREE : ST_FREE_UNALLOC;
            end
         ACT_REALLOC:
            if (it.naddr != 0) begin
               if (it.addr == 0) st = create_region(KIND_HEAP, it.naddr, it.rsize);
               else begin
                  n = find_region(KIND_HEAP, it.addr, 1'b0);
                  if (n >= 0) begin
                     tbl_base[n] = it.naddr;
                     tbl_size[n] = it.rsize;
                     tbl_marks[n] = '0;
                     tbl_age[n] = take_age();
                  end
               end
            end
         ACT_CHK_REALLOC:
            if (it.addr != 0) begin
               if (find_region(KIND_FREED, it.addr, 1'b0) >= 0) st = ST_REALLOC_FREED;
               else if (find_region(KIND_STACK, it.addr, 1'b0) >= 0)
                  st = ST_REALLOC_NONDYN;
            end
         ACT_CHK_STACK, ACT_CHK_GLOBAL: begin
            n = find_region(it.act == ACT_CHK_STACK ? KIND_STACK : KIND_GLOBAL,
                            it.addr, 1'b0);
            st = n >= 0 ? span_status(n, it.addr, it.len) : ST_INVALID_PTR;
         end
         ACT_CHK_HEAP, ACT_CHK_ANY: begin
            n = find_region(KIND_HEAP, it.addr, 1'b0);
            if (n < 0 && it.act == ACT_CHK_ANY) begin
               n = find_region(KIND_STACK, it.addr, 1'b0);
               if (n < 0) n = find_region(KIND_GLOBAL, it.addr, 1'b0);
            end
            if (n >= 0) st = span_status(n, it.addr, it.len);
            else st = find_region(KIND_FREED, it.addr, 1'b0) >= 0 ?
                      ST_FREED_DEREF : ST_INVALID_PTR;
         end
         ACT_MARK: begin
            n = find_region(KIND_STACK, '0, 1'b1);
            if (n >= 0 && tbl_marks[n] != 16'hFFFF) tbl_marks[n]++;
         end
         ACT_DESTROY: begin
            n = find_region(KIND_STACK, it.addr, 1'b0);
            if (n >= 0) tbl_valid[n] = 1'b0;
         end
         ACT_POP_FRAME:
            forever begin
               n = find_region(KIND_STACK, '0, 1'b1);
               if (n < 0) break;
               if (tbl_marks[n] == 0) tbl_valid[n] = 1'b0;
               else begin
                  tbl_marks[n]--;
                  break;
               end
            end
         ACT_LEAKS: if (find_region(KIND_HEAP, '0, 1'b1) >= 0) st = ST_LEAK;
         ACT_FAIL: st = ST_INVALID_DEREF;
         default: ;
      endcase
      return st;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            action_item_type it;
            it = pending_items.pop_front();
            expected_status.push_back(apply_action(it));
            req_valid <= 1'b1;
            req_action <= it.act;
            req_address <= it.addr;
            req_region_size <= it.rsize;
            req_element_count <= it.count;
            req_new_address <= it.naddr;
            req_access_length <= it.len;
            sent++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            received++;
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected item, status %0d", $realtime, rsp_status);
               errors++;
            end else begin
               status_type want;
               want = expected_status.pop_front();
               if (rsp_status !== want) begin
                  $display("%0t: status expected %0d actual %0d", $realtime, want,
                           rsp_status);
                  errors++;
               end
            end
         end
         rsp_stall <= $urandom_range(99) < recv_stall_pct;
      end
   end

   // addresses from a small pool so lookups hit
   function automatic logic [63:0] pick_addr();
      case ($urandom_range(9))
         0: return {$urandom, $urandom};
         1: return 64'd0;
         2: return 64'hFFFF_FFFF_FFFF_FFF0 + $urandom_range(15);
         default: return 64'h1000 * $urandom_range(1, 24) + $urandom_range(0, 40);
      endcase
   endfunction

   function automatic action_item_type random_item();
      action_item_type it;
      it.act = action_type'($urandom_range(15));
      if ($urandom_range(3) == 0) it.act = action_type'($urandom_range(2));
      it.addr = pick_addr();
      if ($urandom_range(2) == 0) it.addr = it.addr & ~64'hFFF;
      it.rsize = $urandom_range(7) == 0 ? {$urandom, $urandom} : $urandom_range(1, 64);
      it.count = $urandom_range(7) == 0 ? 31'($urandom) : 31'($urandom_range(0, 64));
      it.naddr = $urandom_range(5) == 0 ? 64'd0 : pick_addr();
      it.len = $urandom_range(9) == 0 ? {$urandom, $urandom} : $urandom_range(0, 300);
      return it;
   endfunction

   function automatic action_item_type mk(action_type a, logic [63:0] ad,
         logic [63:0] s, logic [30:0] c, logic [63:0] na, logic [63:0] l);
      action_item_type it;
      it.act = a; it.addr = ad; it.rsize = s; it.count = c; it.naddr = na; it.len = l;
      return it;
   endfunction

   task automatic drain();
      while (pending_items.size() != 0 || expected_status.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < Entries; i++) tbl_valid[i] = 1'b0;
      age_next = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: every action, extremes, empty stack, full table
      pending_items.push_back(mk(ACT_MARK, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_POP_FRAME, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_LEAKS, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_REM_HEAP, 64'h2000, 16, 4, 0, 0));
      pending_items.push_back(mk(ACT_REM_HEAP, 0, 16, 4, 0, 0));
      pending_items.push_back(mk(ACT_CHK_HEAP, 64'h2030, 0, 0, 0, 16));
      pending_items.push_back(mk(ACT_CHK_HEAP, 64'h2031, 0, 0, 0, 16));
      pending_items.push_back(mk(ACT_CHK_ANY, 64'h2000, 0, 0, 0, '1));
      pending_items.push_back(mk(ACT_LEAKS, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_FREE, 64'h2008, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_FREE, 64'h2000, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_FREE, 64'h2000, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_CHK_ANY, 64'h2004, 0, 0, 0, 1));
      pending_items.push_back(mk(ACT_CHK_REALLOC, 64'h2004, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_REM_STACK, '1, '1, 31'h7FFF_FFFF, 0, 0));
      pending_items.push_back(mk(ACT_CHK_REALLOC, '1, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_CHK_STACK, '1, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_REM_GLOBAL, 64'h9000, 64'h100, 0, 0, 0));
      pending_items.push_back(mk(ACT_CHK_GLOBAL, 64'h90FF, 0, 0, 0, 2));
      pending_items.push_back(mk(ACT_REALLOC, 0, 32, 0, 64'h5000, 0));
      pending_items.push_back(mk(ACT_REALLOC, 64'h5000, 64, 0, 64'h6000, 0));
      pending_items.push_back(mk(ACT_DESTROY, '1, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_FAIL, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_NONE, '1, '1, '1, '1, '1));
      drain();
      // frame marks on one stack entry, then pop some of them
      pending_items.push_back(mk(ACT_REM_STACK, 64'h7000, 8, 2, 0, 0));
      repeat (5) pending_items.push_back(mk(ACT_MARK, 0, 0, 0, 0, 0));
      repeat (3) pending_items.push_back(mk(ACT_POP_FRAME, 0, 0, 0, 0, 0));
      // fill the table to overflow
      for (int i = 0; i < Entries + 2; i++)
         pending_items.push_back(mk(ACT_REM_STACK, 64'h100_0000 + 64'h100 * i, 16, 1, 0, 0));
      pending_items.push_back(mk(ACT_REM_HEAP, 64'h300_0000, 4, 4, 0, 0));
      drain();
      // resize the same stack regions again, then pop frames
      for (int i = 0; i < Entries + 2; i++)
         pending_items.push_back(mk(ACT_REM_STACK, 64'h100_0000 + 64'h100 * i, 1, 1, 0, 0));
      pending_items.push_back(mk(ACT_POP_FRAME, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(ACT_POP_FRAME, 0, 0, 0, 0, 0));
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 28 : 52) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 28 : 52) : 0;
         for (int k = 0; k < 400; k++) begin
            pending_items.push_back(random_item());
            // keep the table from clogging up
            if (k % 60 == 59) begin
               repeat (4) pending_items.push_back(mk(ACT_POP_FRAME, 0, 0, 0, 0, 0));
            end
         end
         drain();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (200) @(posedge clock);
      $display("ran %0d actions and checked %0d statuses, with stalls, a full table",
               sent, received);
      $display("and long frame pops");
      if (errors == 0 && expected_status.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
